[rtl/core/rnrc_pkg.sv]
// Shared types and constants for the raster neighborhood rule classifier.
// Holds the rule ROM, neighbor code bit positions and the border flag struct.
// No dependencies.
package rnrc_pkg;

  // Fixed field widths of the result item, the frame registers and the APB bus
  localparam int unsigned RowOutW  = 10;
  localparam int unsigned ColOutW  = 10;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned RuleW    = 5;
  localparam int unsigned CfgW     = 11;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  // Register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Reset values of the frame registers
  localparam logic [CfgW-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CfgW-1:0] FRAME_HEIGHT_RST = 11'd480;

  // Bit positions in the neighbor code
  localparam int unsigned CODE_NE = 0;
  localparam int unsigned CODE_E  = 1;
  localparam int unsigned CODE_SE = 2;
  localparam int unsigned CODE_S  = 3;
  localparam int unsigned CODE_SW = 4;
  localparam int unsigned CODE_W  = 5;
  localparam int unsigned CODE_NW = 6;
  localparam int unsigned CODE_N  = 7;

  // Image border flags of one centre pixel
  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
  } border_t;

  // Neighbor code to vectorization rule; code 200 resolves to rule 10
  localparam logic [RuleW-1:0] RULE_ROM [256] = '{
    5'd1, 5'd3, 5'd2, 5'd2, 5'd2, 5'd7, 5'd2, 5'd2,
    5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2,
    5'd2, 5'd7, 5'd2, 5'd2, 5'd2, 5'd3, 5'd2, 5'd2,
    5'd2, 5'd7, 5'd2, 5'd2, 5'd2, 5'd7, 5'd2, 5'd2,
    5'd4, 5'd11, 5'd8, 5'd8, 5'd8, 5'd14, 5'd8, 5'd8,
    5'd8, 5'd14, 5'd4, 5'd4, 5'd8, 5'd14, 5'd4, 5'd4,
    5'd4, 5'd11, 5'd8, 5'd8, 5'd8, 5'd14, 5'd8, 5'd8,
    5'd4, 5'd14, 5'd4, 5'd4, 5'd4, 5'd14, 5'd4, 5'd4,
    5'd5, 5'd12, 5'd5, 5'd5, 5'd9, 5'd15, 5'd5, 5'd5,
    5'd5, 5'd15, 5'd5, 5'd5, 5'd5, 5'd15, 5'd5, 5'd5,
    5'd9, 5'd15, 5'd5, 5'd5, 5'd5, 5'd15, 5'd5, 5'd5,
    5'd5, 5'd15, 5'd5, 5'd5, 5'd5, 5'd15, 5'd5, 5'd5,
    5'd4, 5'd11, 5'd8, 5'd8, 5'd8, 5'd14, 5'd8, 5'd8,
    5'd8, 5'd14, 5'd4, 5'd4, 5'd8, 5'd14, 5'd4, 5'd4,
    5'd4, 5'd11, 5'd8, 5'd8, 5'd8, 5'd14, 5'd8, 5'd8,
    5'd4, 5'd14, 5'd4, 5'd4, 5'd4, 5'd14, 5'd4, 5'd4,
    5'd6, 5'd6, 5'd10, 5'd6, 5'd10, 5'd10, 5'd10, 5'd6,
    5'd10, 5'd10, 5'd6, 5'd6, 5'd10, 5'd10, 5'd6, 5'd6,
    5'd6, 5'd10, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
    5'd10, 5'd10, 5'd6, 5'd6, 5'd10, 5'd10, 5'd6, 5'd6,
    5'd13, 5'd13, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd13, 5'd13, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd6, 5'd6, 5'd10, 5'd6, 5'd10, 5'd10, 5'd10, 5'd6,
    5'd10, 5'd10, 5'd6, 5'd6, 5'd10, 5'd10, 5'd6, 5'd6,
    5'd10, 5'd10, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
    5'd10, 5'd10, 5'd6, 5'd6, 5'd10, 5'd10, 5'd6, 5'd6,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16
  };

endpackage

[rtl/core/raster_neighborhood_rule_classifier_core.sv]
// Raster neighborhood rule classifier: takes one pixel item per clock in row order
// (plus width+1 flush items after each frame) unless the output stalls, and emits
// one result item per line pixel: its position, 8-bit neighbor code and rule number.
// Throughput is one item per clock without stalls, set by the single read and write
// port pair of the line store that every item uses once. The line store needs no
// clearing after reset: a column is always written in the current frame before it
// is read as an in-image neighbor.
// Depends on rnrc_pkg, rnrc_apb_regs, rnrc_line_store and rnrc_classify.
module raster_neighborhood_rule_classifier_core
  import rnrc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [7:0]          pixel_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RowOutW-1:0]  center_row_o,
  output logic [ColOutW-1:0]  center_col_o,
  output logic [CodeW-1:0]    neighbor_code_o,
  output logic [RuleW-1:0]    rule_number_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

  logic [WW-1:0] w_use;
  logic [HW-1:0] h_use;
  logic [RW-1:0] h_ext;
  logic          restart;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [WW-1:0] col_inc;

  logic          advance, accept;
  logic          new_bit;
  logic          center_ok;
  logic [RW-1:0] cr;
  logic [CW-1:0] cc;
  border_t       border;

  logic          stg_valid_q;
  logic          stg_new_bit_q;
  logic          stg_center_ok_q;
  logic [RW-1:0] stg_row_q;
  logic [CW-1:0] stg_col_q;
  logic [CW-1:0] stg_addr_q;
  border_t       stg_border_q;

  logic [1:0]    rd_data;
  logic [1:0]    wr_data;
  logic          wr_en;

  rnrc_apb_regs #(
    .MaxWidth (MAX_WIDTH),
    .MaxHeight(MAX_HEIGHT),
    .WW       (WW),
    .HW       (HW)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .width_use_o (w_use),
    .height_use_o(h_use),
    .restart_o   (restart)
  );

  assign h_ext = RW'(h_use);

  // Hold the whole pipe while a result waits on a stalled output
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  // Incoming pixel is a line pixel only inside the image
  assign new_bit = (row_q < h_ext) && !command_i && (pixel_value_i == 8'd0);

  // Locate the centre that lies width+1 items behind the incoming one
  always_comb begin
    center_ok = 1'b0;
    cr        = '0;
    cc        = '0;
    if (col_q != '0) begin
      if (row_q >= RW'(1)) begin
        center_ok = 1'b1;
        cr        = row_q - RW'(1);
        cc        = col_q - CW'(1);
      end
    end else if (row_q >= RW'(2)) begin
      center_ok = 1'b1;
      cr        = row_q - RW'(2);
      cc        = CW'(w_use - WW'(1));
    end
    if (cr >= h_ext) begin
      center_ok = 1'b0;
    end
    border.top = (cr == '0);
    border.bot = (cr == h_ext - RW'(1));
    border.lft = (cc == '0);
    border.rgt = (WW'(cc) == w_use - WW'(1));
  end

  // Advance the raster position; wrap after the last flush item
  assign col_inc = WW'(col_q) + WW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if ((row_q >= h_ext + RW'(1)) && (col_q == '0)) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= w_use) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (advance) begin
        stg_valid_q <= accept;
      end
    end
  end

  // Capture the item's centre data alongside the store read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_new_bit_q   <= new_bit;
      stg_center_ok_q <= center_ok;
      stg_row_q       <= cr;
      stg_col_q       <= cc;
      stg_addr_q      <= col_q;
      stg_border_q    <= border;
    end
  end

  // Read the column on accept, write it back from the staging register when the pipe advances
  assign wr_en = advance && stg_valid_q;

  rnrc_line_store #(
    .Depth(MAX_WIDTH),
    .AddrW(CW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(col_q),
    .wr_en_i  (wr_en),
    .wr_addr_i(stg_addr_q),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  rnrc_classify #(
    .RW(RW),
    .CW(CW)
  ) u_classify (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .stg_valid_i    (stg_valid_q),
    .stg_new_bit_i  (stg_new_bit_q),
    .stg_center_ok_i(stg_center_ok_q),
    .stg_row_i      (stg_row_q),
    .stg_col_i      (stg_col_q),
    .stg_border_i   (stg_border_q),
    .rd_data_i      (rd_data),
    .wr_data_o      (wr_data),
    .out_valid_o    (out_valid_o),
    .center_row_o   (center_row_o),
    .center_col_o   (center_col_o),
    .neighbor_code_o(neighbor_code_o),
    .rule_number_o  (rule_number_o)
  );

endmodule

[rtl/core/rnrc_line_store.sv]
// Two-row line store: one synchronous memory, 2 bits per column {upper, middle}.
// Registered read, with forwarding of a same-cycle write to the read address.
// No package dependencies.
module rnrc_line_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [1:0]       wr_data_i,
  output logic [1:0]       rd_data_o
);

  logic [1:0] mem [Depth];
  logic [1:0] rd_q;
  logic [1:0] fwd_data_q;
  logic       fwd_q;

  // Write back and read the array; the read returns the old contents
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Track whether the read hit the entry being written in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

[rtl/core/rnrc_apb_regs.sv]
// APB register file holding frame width and height, with saturated used values.
// Depends on rnrc_pkg for register indexes, widths and reset values.
module rnrc_apb_regs
  import rnrc_pkg::*;
#(
  parameter int unsigned MaxWidth  = 1024,
  parameter int unsigned MaxHeight = 1024,
  parameter int unsigned WW        = 11,
  parameter int unsigned HW        = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic [WW-1:0]       width_use_o,
  output logic [HW-1:0]       height_use_o,
  output logic                restart_o
);

  localparam int unsigned XW = (WW > CfgW) ? WW : CfgW;
  localparam int unsigned YW = (HW > CfgW) ? HW : CfgW;

  logic [CfgW-1:0] frame_width_q, frame_width_d;
  logic [CfgW-1:0] frame_height_q, frame_height_d;
  logic            wr_en;
  logic [XW-1:0]   w_ext;
  logic [YW-1:0]   h_ext;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Decode writes by register index
  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_d  = pwdata[CfgW-1:0];
        REG_FRAME_HEIGHT: frame_height_d = pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  // Return register contents on read
  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = ApbDataW'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = ApbDataW'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  // Any write restarts the frame
  assign restart_o = wr_en;

  // Saturate the used dimensions to [2, max]
  always_comb begin
    w_ext = XW'(frame_width_q);
    h_ext = YW'(frame_height_q);
    if (w_ext < XW'(2)) begin
      w_ext = XW'(2);
    end else if (w_ext > XW'(MaxWidth)) begin
      w_ext = XW'(MaxWidth);
    end
    if (h_ext < YW'(2)) begin
      h_ext = YW'(2);
    end else if (h_ext > YW'(MaxHeight)) begin
      h_ext = YW'(MaxHeight);
    end
  end

  assign width_use_o  = w_ext[WW-1:0];
  assign height_use_o = h_ext[HW-1:0];

endmodule

[rtl/core/rnrc_classify.sv]
// Window stage and result register: shifts the 3x3 window, builds the neighbor
// code, looks up the rule and holds the result item. Depends on rnrc_pkg.
module rnrc_classify
  import rnrc_pkg::*;
#(
  parameter int unsigned RW = 11,
  parameter int unsigned CW = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic               stg_valid_i,
  input  logic               stg_new_bit_i,
  input  logic               stg_center_ok_i,
  input  logic [RW-1:0]      stg_row_i,
  input  logic [CW-1:0]      stg_col_i,
  input  border_t            stg_border_i,
  input  logic [1:0]         rd_data_i,
  output logic [1:0]         wr_data_o,
  output logic               out_valid_o,
  output logic [RowOutW-1:0] center_row_o,
  output logic [ColOutW-1:0] center_col_o,
  output logic [CodeW-1:0]   neighbor_code_o,
  output logic [RuleW-1:0]   rule_number_o
);

  logic [8:0]       win_q, win_d;
  logic             up_in, mid_in;
  logic [CodeW-1:0] code;
  logic             emit;
  logic             out_valid_q;
  logic [RowOutW-1:0] row_q;
  logic [ColOutW-1:0] col_q;
  logic [CodeW-1:0]   code_q;
  logic [RuleW-1:0]   rule_q;

  assign up_in  = rd_data_i[1];
  assign mid_in = rd_data_i[0];

  // Push the middle row down a line and store the new pixel
  assign wr_data_o = {mid_in, stg_new_bit_i};

  // Shift each window row left by one column, newest column on the right
  assign win_d = {stg_new_bit_i, win_q[8:7], mid_in, win_q[5:4], up_in, win_q[2:1]};

  // Build the neighbor code, masking neighbors outside the image
  always_comb begin
    code          = '0;
    code[CODE_NE] = win_d[2] && !stg_border_i.top && !stg_border_i.rgt;
    code[CODE_E]  = win_d[5] && !stg_border_i.rgt;
    code[CODE_SE] = win_d[8] && !stg_border_i.bot && !stg_border_i.rgt;
    code[CODE_S]  = win_d[7] && !stg_border_i.bot;
    code[CODE_SW] = win_d[6] && !stg_border_i.bot && !stg_border_i.lft;
    code[CODE_W]  = win_d[3] && !stg_border_i.lft;
    code[CODE_NW] = win_d[0] && !stg_border_i.top && !stg_border_i.lft;
    code[CODE_N]  = win_d[1] && !stg_border_i.top;
  end

  assign emit = stg_valid_i && stg_center_ok_i && win_d[4];

  // Advance the window once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance_i) begin
      if (stg_valid_i) begin
        win_q <= win_d;
      end
      out_valid_q <= emit;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (advance_i && emit) begin
      row_q  <= RowOutW'(stg_row_i);
      col_q  <= ColOutW'(stg_col_i);
      code_q <= code;
      rule_q <= RULE_ROM[code];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign center_row_o    = row_q;
  assign center_col_o    = col_q;
  assign neighbor_code_o = code_q;
  assign rule_number_o   = rule_q;

endmodule

[tb/raster_neighborhood_rule_classifier_core_tb.sv]
// Self-checking testbench for raster_neighborhood_rule_classifier_core.
// Streams raster frames, predicts each line-pixel result and checks every result item.
// Depends on rnrc_pkg and the classifier core RTL.
`timescale 1ns / 1ps

module raster_neighborhood_rule_classifier_core_tb;
  import rnrc_pkg::*;

  localparam int unsigned MAX_DIM        = 1024;
  localparam int unsigned DEFAULT_WIDTH  = 640;
  localparam int unsigned DEFAULT_HEIGHT = 480;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam int unsigned RANDOM_ITEMS   = 250;
  localparam int unsigned MAX_REPORTS    = 10;

  // Item commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Neighbor code to vectorization rule
  localparam int unsigned RULE_TABLE [256] = '{
    1, 3, 2, 2, 2, 7, 2, 2, 2, 2, 2, 2, 2, 2, 2, 2,
    2, 7, 2, 2, 2, 3, 2, 2, 2, 7, 2, 2, 2, 7, 2, 2,
    4, 11, 8, 8, 8, 14, 8, 8, 8, 14, 4, 4, 8, 14, 4, 4,
    4, 11, 8, 8, 8, 14, 8, 8, 4, 14, 4, 4, 4, 14, 4, 4,
    5, 12, 5, 5, 9, 15, 5, 5, 5, 15, 5, 5, 5, 15, 5, 5,
    9, 15, 5, 5, 5, 15, 5, 5, 5, 15, 5, 5, 5, 15, 5, 5,
    4, 11, 8, 8, 8, 14, 8, 8, 8, 14, 4, 4, 8, 14, 4, 4,
    4, 11, 8, 8, 8, 14, 8, 8, 4, 14, 4, 4, 4, 14, 4, 4,
    6, 6, 10, 6, 10, 10, 10, 6, 10, 10, 6, 6, 10, 10, 6, 6,
    6, 10, 6, 6, 6, 6, 6, 6, 10, 10, 6, 6, 10, 10, 6, 6,
    13, 13, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16,
    13, 13, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16,
    6, 6, 10, 6, 10, 10, 10, 6, 10, 10, 6, 6, 10, 10, 6, 6,
    10, 10, 6, 6, 6, 6, 6, 6, 10, 10, 6, 6, 10, 10, 6, 6,
    16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16,
    16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16
  };

  // 3x3 frame whose centre sees N, NW and S only (code 200), with gray extremes,
  // a flush mid frame and a pixel during the flush
  localparam logic [8:0] CORNER_FRAME [13] = '{
    {CMD_PIXEL, 8'h00}, {CMD_PIXEL, 8'h00}, {CMD_PIXEL, 8'hFF},
    {CMD_PIXEL, 8'h01}, {CMD_PIXEL, 8'h00}, {CMD_PIXEL, 8'h80},
    {CMD_FLUSH, 8'h00}, {CMD_PIXEL, 8'h00}, {CMD_PIXEL, 8'hFE},
    {CMD_PIXEL, 8'h00}, {CMD_FLUSH, 8'hFF}, {CMD_FLUSH, 8'h00}, {CMD_PIXEL, 8'h00}
  };

  typedef struct packed {
    logic [RowOutW-1:0] row;
    logic [ColOutW-1:0] col;
    logic [CodeW-1:0]   code;
    logic [RuleW-1:0]   rule;
  } line_pixel_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_SOLID
  } stall_mode_e;

  // DUT signals
  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ApbAddrW-1:0] paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic                command     = CMD_PIXEL;
  logic [7:0]          pixel_value = 8'h00;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [RowOutW-1:0]  center_row;
  logic [ColOutW-1:0]  center_col;
  logic [CodeW-1:0]    neighbor_code;
  logic [RuleW-1:0]    rule_number;

  // Predictor state
  logic [CfgW-1:0] width_reg  = CfgW'(DEFAULT_WIDTH);
  logic [CfgW-1:0] height_reg = CfgW'(DEFAULT_HEIGHT);
  bit              upper_row  [MAX_DIM];
  bit              middle_row [MAX_DIM];
  bit [8:0]        win;
  int unsigned     in_row;
  int unsigned     in_col;
  line_pixel_t     pending_centers [$];

  int unsigned mismatches;
  int unsigned item_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left;

  raster_neighborhood_rule_classifier_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .pixel_value_i   (pixel_value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .center_row_o    (center_row),
    .center_col_o    (center_col),
    .neighbor_code_o (neighbor_code),
    .rule_number_o   (rule_number)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Clamp a frame register to the range the block uses
  function automatic int unsigned dim_used(logic [CfgW-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned frame_len();
    return dim_used(width_reg) * dim_used(height_reg) + dim_used(width_reg) + 1;
  endfunction

  // Advance the line stores and window by one item; queue the centre if it is a line pixel
  function automatic void classify_item(logic cmd, logic [7:0] pix);
    int unsigned      w;
    int unsigned      h;
    int unsigned      col;
    int unsigned      row;
    int unsigned      cr;
    int unsigned      cc;
    bit               new_b;
    bit               up_b;
    bit               mid_b;
    bit               hit;
    logic [CodeW-1:0] code;
    border_t          bord;
    line_pixel_t      res;
    w    = dim_used(width_reg);
    h    = dim_used(height_reg);
    col  = in_col;
    row  = in_row;
    cr   = 0;
    cc   = 0;
    hit  = 1'b0;
    code = '0;
    if (col >= w || row > h + 1) begin
      col = 0;
      row = 0;
    end
    // anything past the last image row is background
    new_b = (row < h) && (cmd == CMD_PIXEL) && (pix == 8'h00);
    up_b  = upper_row[col];
    mid_b = middle_row[col];
    upper_row[col]  = mid_b;
    middle_row[col] = new_b;
    // shift each window row one column older, newest column enters on the right
    win = {new_b, win[8:7], mid_b, win[5:4], up_b, win[2:1]};
    // centre lies width+1 positions behind the incoming item
    if (col >= 1) begin
      if (row >= 1) begin
        cr  = row - 1;
        cc  = col - 1;
        hit = 1'b1;
      end
    end else if (row >= 2) begin
      cr  = row - 2;
      cc  = w - 1;
      hit = 1'b1;
    end
    if (hit && cr >= h) hit = 1'b0;
    if (hit && win[4]) begin
      bord.top = (cr == 0);
      bord.bot = (cr == h - 1);
      bord.lft = (cc == 0);
      bord.rgt = (cc == w - 1);
      // mask neighbors that fall outside the image
      code[CODE_NE] = !bord.top && !bord.rgt && win[2];
      code[CODE_E]  = !bord.rgt && win[5];
      code[CODE_SE] = !bord.bot && !bord.rgt && win[8];
      code[CODE_S]  = !bord.bot && win[7];
      code[CODE_SW] = !bord.bot && !bord.lft && win[6];
      code[CODE_W]  = !bord.lft && win[3];
      code[CODE_NW] = !bord.top && !bord.lft && win[0];
      code[CODE_N]  = !bord.top && win[1];
      res.row  = cr[RowOutW-1:0];
      res.col  = cc[ColOutW-1:0];
      res.code = code;
      res.rule = RuleW'(RULE_TABLE[code]);
      pending_centers.push_back(res);
    end
    // wrap to a new frame after the last flush item
    if (row >= h + 1 && col == 0) begin
      in_row = 0;
      in_col = 0;
    end else begin
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
      in_row = row;
      in_col = col;
    end
  endfunction

  // Send one item, with a random gap at the start of each burst
  task automatic push_pixel(input logic cmd, input logic [7:0] pix);
    int unsigned gap;
    logic        stalled;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                 $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    command     <= cmd;
    pixel_value <= pix;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    classify_item(cmd, pix);
    item_count++;
  endtask

  // Drop valid and wait until every queued result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_centers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Read one frame register over APB and compare it with the expected value
  task automatic check_register(input logic idx, input logic [CfgW-1:0] val);
    logic [ApbDataW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    readback = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback !== ApbDataW'(val)) begin
      note_failure($sformatf("register %0d read: expected 0x%0h, got 0x%0h",
                             idx, val, readback));
    end
  endtask

  // Write one frame register over APB, then read it back
  task automatic write_register(input logic idx, input logic [CfgW-1:0] val);
    logic [ApbDataW-1:0] junk;
    logic [ApbDataW-1:0] readback;
    junk = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[ApbDataW-1:CfgW], val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // register takes the value here and the frame restarts
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    in_row = 0;
    in_col = 0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    readback = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback !== ApbDataW'(val)) begin
      note_failure($sformatf("register %0d readback: expected 0x%0h, got 0x%0h",
                             idx, val, readback));
    end
  endtask

  task automatic set_geometry(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    wait_drained();
    write_register(REG_FRAME_WIDTH, w);
    write_register(REG_FRAME_HEIGHT, h);
  endtask

  // Send n items at the current geometry; items past the image are flush items
  task automatic send_frame(input int unsigned n, input int unsigned density,
                            input int unsigned noise);
    int unsigned pixels;
    logic        cmd;
    logic [7:0]  pix;
    pixels = dim_used(width_reg) * dim_used(height_reg);
    for (int unsigned i = 0; i < n; i++) begin
      cmd = (i >= pixels) ? CMD_FLUSH : CMD_PIXEL;
      pix = ($urandom_range(0, 99) < density) ? 8'h00 : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < noise) cmd = ~cmd;
      push_pixel(cmd, pix);
    end
  endtask

  // Check that both frame registers come out of reset with their defaults
  task automatic test_reset_geometry();
    check_register(REG_FRAME_WIDTH, CfgW'(DEFAULT_WIDTH));
    check_register(REG_FRAME_HEIGHT, CfgW'(DEFAULT_HEIGHT));
  endtask

  // Full 3x3 frame of line pixels, then the code 200 frame
  task automatic test_directed_frames();
    set_geometry(11'd3, 11'd3);
    repeat (9) push_pixel(CMD_PIXEL, 8'h00);
    repeat (4) push_pixel(CMD_FLUSH, 8'h00);
    for (int i = 0; i < 13; i++) push_pixel(CORNER_FRAME[i][8], CORNER_FRAME[i][7:0]);
  endtask

  // Register extremes, saturated both ways; the widest frame runs just past its first
  // row so the wrap at the saturated width shows in the result columns
  task automatic test_size_extremes();
    set_geometry(11'd0, 11'd1);
    send_frame(frame_len(), 50, 0);
    set_geometry(11'd1, 11'd2);
    send_frame(frame_len(), 50, 0);
    set_geometry(11'd2047, 11'd0);
    send_frame(MAX_DIM + 3, 60, 0);
  endtask

  // Mostly well-formed small frames, some truncated or noisy
  task automatic test_random_frames();
    int unsigned start;
    int unsigned w;
    int unsigned h;
    int unsigned mode;
    int unsigned n;
    bit          first;
    start = item_count;
    first = 1'b1;
    while (item_count - start < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 64) : $urandom_range(2, 9);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1);
      h = $urandom_range(2, 8);
      if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 1);
      mode  = first ? 0 : $urandom_range(0, 9);
      first = 1'b0;
      if (mode < 7) begin
        set_geometry(CfgW'(w), CfgW'(h));
      end else if (mode < 9) begin
        wait_drained();
        write_register(REG_FRAME_HEIGHT, CfgW'(h));
      end
      n = frame_len();
      if ($urandom_range(0, 6) == 0) send_frame($urandom_range(1, 2 * n), 50, 30);
      else send_frame(n, $urandom_range(20, 80), 0);
    end
  endtask

  // Receiver stall pattern, switching mode every stretch
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = (stall_mode == STALL_SOLID) ? $urandom_range(3, 30) :
                                                  $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      default:     out_stall <= 1'b1;
    endcase
  end

  // Check each accepted result against the oldest expectation
  initial begin
    logic        take;
    line_pixel_t got;
    line_pixel_t want;
    forever begin
      @(negedge clk);
      take     = (out_valid === 1'b1) && !out_stall;
      got.row  = center_row;
      got.col  = center_col;
      got.code = neighbor_code;
      got.rule = rule_number;
      @(posedge clk);
      if (take) begin
        if (pending_centers.size() == 0) begin
          note_failure($sformatf("unexpected result: row %0d col %0d code %0d rule %0d",
                                 got.row, got.col, got.code, got.rule));
        end else begin
          want = pending_centers.pop_front();
          if (got.row !== want.row || got.col !== want.col ||
              got.code !== want.code || got.rule !== want.rule) begin
            note_failure($sformatf({"result mismatch: expected row %0d col %0d code %0d ",
                                    "rule %0d, got row %0d col %0d code %0d rule %0d"},
                                   want.row, want.col, want.code, want.rule,
                                   got.row, got.col, got.code, got.rule));
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("raster_neighborhood_rule_classifier_core verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_directed_frames();
    test_size_extremes();
    test_random_frames();
    wait_drained();
    if (mismatches == 0) begin
      $display("raster_neighborhood_rule_classifier_core verification clean");
    end else begin
      $display("raster_neighborhood_rule_classifier_core verification failed");
    end
    $finish;
  end

endmodule
